[src/mstmr_pkg.sv]
// Shared types and constants for the multi-slot millisecond countdown timer.
`timescale 1ns / 1ps

package mstmr_pkg;

	localparam int DEF_NUM_SLOTS = 8;

	localparam int CMD_W   = 2;
	localparam int SLOT_FW = 8;
	localparam int COUNT_W = 16;
	localparam int FRACT_W = 8;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 8;

	localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_SET   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CHECK = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_FRACT_INCREMENT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRACT_LIMIT     = 1'd1;

	localparam logic [FRACT_W-1:0] FRACT_INCREMENT_RST = 8'd3;
	localparam logic [FRACT_W-1:0] FRACT_LIMIT_RST     = 8'd125;

	typedef struct packed {
		logic               positive;
		logic [COUNT_W-1:0] next;
	} alu_res_t;

endpackage

[src/mstmr_if.sv]
// Valid/ready channel interfaces for commands and check responses.
`timescale 1ns / 1ps

interface mstmr_req_if;
	logic                         valid;
	logic                         ready;
	logic [mstmr_pkg::CMD_W-1:0]   command;
	logic [mstmr_pkg::SLOT_FW-1:0] slot;
	logic [mstmr_pkg::COUNT_W-1:0] duration_ms;

	modport source (output valid, command, slot, duration_ms, input ready);
	modport sink   (input valid, command, slot, duration_ms, output ready);
endinterface

interface mstmr_rsp_if;
	logic valid;
	logic ready;
	logic expired;

	modport source (output valid, expired, input ready);
	modport sink   (input valid, expired, output ready);
endinterface

[src/mstmr_alu.sv]
// Shared count unit: positive test and step decrement of one slot count.
`timescale 1ns / 1ps

module mstmr_alu (
	input  logic [mstmr_pkg::COUNT_W-1:0] count,
	input  logic                          step_two,
	output mstmr_pkg::alu_res_t           res
);
	import mstmr_pkg::*;

	logic [COUNT_W-1:0] step;

	assign step         = step_two ? COUNT_W'(2) : COUNT_W'(1);
	assign res.positive = (count != '0) && !count[COUNT_W-1];
	assign res.next     = count - step;

endmodule

[src/mstmr_slot_ram.sv]
// Slot count memory with per-entry valid bits; unwritten entries read as zero.
`timescale 1ns / 1ps

module mstmr_slot_ram #(
	parameter int DEPTH = mstmr_pkg::DEF_NUM_SLOTS,
	parameter int AW    = 3
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [AW-1:0]                 wr_addr,
	input  logic [mstmr_pkg::COUNT_W-1:0] wr_data,
	input  logic [AW-1:0]                 rd_addr,
	output logic [mstmr_pkg::COUNT_W-1:0] rd_data
);
	import mstmr_pkg::*;

	logic [COUNT_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0]   vld_q;
	logic [COUNT_W-1:0] rd_data_q;
	logic               rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			rd_vld_q <= vld_q[rd_addr];
		end
	end

	assign rd_data = rd_vld_q ? rd_data_q : '0;

endmodule

[src/multi_slot_ms_countdown_timer.sv]
// Top level of the multi-slot millisecond countdown timer.
//
//   channel  dir  handshake          payload
//   req      in   valid/ready        command, slot, duration_ms
//   rsp      out  valid/ready        expired (one beat per check)
//   cfg      in   cfg_wr_en          cfg_index, cfg_data (no back-pressure)
//
// A set is written in the cycle it is accepted. A check reads its slot and
// raises its response beat once the previous beat has been taken. After a
// tick is accepted, the single count unit walks the slot memory one slot per
// cycle, reading one slot while writing back the previous one. Reset clears
// all slots to zero through the memory's valid bits, with no clearing pass.
// req.ready is low while a tick walk or a check is in progress.
`timescale 1ns / 1ps

module multi_slot_ms_countdown_timer #(
	parameter int NUM_SLOTS = mstmr_pkg::DEF_NUM_SLOTS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	mstmr_req_if.sink                        req,
	mstmr_rsp_if.source                      rsp,
	input  logic                             cfg_wr_en,
	input  logic [mstmr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mstmr_pkg::CFG_DATA_W-1:0] cfg_data
);
	import mstmr_pkg::*;

	localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CNT_W  = $clog2(NUM_SLOTS + 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_WALK = 2'd1;
	localparam logic [1:0] ST_CHK  = 2'd2;

	logic [1:0]         state_q;
	logic [FRACT_W-1:0] fract_inc_q;
	logic [FRACT_W-1:0] fract_lim_q;
	logic [FRACT_W-1:0] accum_q;
	logic               step_two_q;
	logic [CNT_W-1:0]   rd_cnt_q;
	logic               pend_s1;
	logic [SLOT_W-1:0]  wr_idx_s1;
	logic [SLOT_W-1:0]  chk_idx_q;
	logic               oor_q;
	logic               rsp_valid_q;
	logic               expired_q;

	logic               acc;
	logic               in_range;
	logic [SLOT_W-1:0]  req_idx;
	logic [FRACT_W-1:0] acc_sum;
	logic               issue;
	logic               walk_done;
	logic               rsp_free;

	logic               mem_wr_en;
	logic [SLOT_W-1:0]  mem_wr_addr;
	logic [COUNT_W-1:0] mem_wr_data;
	logic [SLOT_W-1:0]  mem_rd_addr;
	logic [COUNT_W-1:0] mem_rd_data;
	alu_res_t           alu_res;

	assign req.ready = (state_q == ST_IDLE);
	assign acc       = req.valid && req.ready;
	assign in_range  = ({1'b0, req.slot} < 9'(NUM_SLOTS));
	assign req_idx   = req.slot[SLOT_W-1:0];
	assign acc_sum   = accum_q + fract_inc_q;
	assign issue     = (state_q == ST_WALK) && (rd_cnt_q < CNT_W'(NUM_SLOTS));
	assign walk_done = pend_s1 && (wr_idx_s1 == SLOT_W'(NUM_SLOTS - 1));
	assign rsp_free  = !rsp_valid_q || rsp.ready;

	mstmr_alu u_alu (
		.count    (mem_rd_data),
		.step_two (step_two_q),
		.res      (alu_res)
	);

	mstmr_slot_ram #(
		.DEPTH (NUM_SLOTS),
		.AW    (SLOT_W)
	) u_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data)
	);

	// The walk's write-back and a set never meet: sets are taken only in idle.
	always_comb begin
		if (state_q == ST_WALK) begin
			mem_wr_en   = pend_s1 && alu_res.positive;
			mem_wr_addr = wr_idx_s1;
			mem_wr_data = alu_res.next;
		end else begin
			mem_wr_en   = acc && (req.command == CMD_SET) && in_range;
			mem_wr_addr = req_idx;
			mem_wr_data = req.duration_ms;
		end
	end

	always_comb begin
		case (state_q)
			ST_WALK: mem_rd_addr = rd_cnt_q[SLOT_W-1:0];
			ST_CHK:  mem_rd_addr = chk_idx_q;
			default: mem_rd_addr = req_idx;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fract_inc_q <= FRACT_INCREMENT_RST;
			fract_lim_q <= FRACT_LIMIT_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_FRACT_INCREMENT: fract_inc_q <= cfg_data;
				CFG_FRACT_LIMIT:     fract_lim_q <= cfg_data;
				default:             ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			accum_q     <= '0;
			step_two_q  <= 1'b0;
			rd_cnt_q    <= '0;
			pend_s1     <= 1'b0;
			wr_idx_s1   <= '0;
			chk_idx_q   <= '0;
			oor_q       <= 1'b0;
			rsp_valid_q <= 1'b0;
			expired_q   <= 1'b0;
		end else begin
			if ((state_q == ST_CHK) && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (acc && (req.command == CMD_TICK)) begin
						// The limit is taken off at most once per tick.
						if (acc_sum >= fract_lim_q) begin
							accum_q    <= acc_sum - fract_lim_q;
							step_two_q <= 1'b1;
						end else begin
							accum_q    <= acc_sum;
							step_two_q <= 1'b0;
						end
						rd_cnt_q <= '0;
						pend_s1  <= 1'b0;
						state_q  <= ST_WALK;
					end else if (acc && (req.command == CMD_CHECK)) begin
						chk_idx_q <= req_idx;
						oor_q     <= !in_range;
						state_q   <= ST_CHK;
					end
				end
				ST_WALK: begin
					// No read is issued in the cycle of the last write-back.
					pend_s1   <= issue;
					wr_idx_s1 <= rd_cnt_q[SLOT_W-1:0];
					if (issue) begin
						rd_cnt_q <= rd_cnt_q + CNT_W'(1);
					end
					if (walk_done) begin
						state_q <= ST_IDLE;
					end
				end
				ST_CHK: begin
					if (rsp_free) begin
						expired_q <= oor_q || !alu_res.positive;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign rsp.valid   = rsp_valid_q;
	assign rsp.expired = expired_q;

	a_check_enters_chk: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && (req.command == CMD_CHECK)) |=> (state_q == ST_CHK))
		else $error("accepted check did not start a slot read");

	a_walk_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> ({1'b0, wr_idx_s1} < (SLOT_W + 1)'(NUM_SLOTS)))
		else $error("tick walk write-back beyond the last slot");

	a_rsp_from_check: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> ($past(state_q) == ST_CHK))
		else $error("response beat raised outside a check");

	a_walk_blocks_req: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && (req.command == CMD_TICK)) |=> !req.ready)
		else $error("new beat accepted while a tick walk runs");

endmodule
